// ===== hdl/nplm_pkg.sv =====
// ----------------------------------------------------------------------------
// nplm_pkg
// Types and constants shared by the packet latency monitor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nplm_pkg;

	localparam int MAX_PORTS = 4;
	localparam int FIELD_W   = 16;
	localparam int STAMP_W   = 64;
	localparam int LIMIT_W   = 16;
	localparam int IDLE_W    = 17;
	localparam int INFL_W    = 3;
	localparam int POS_W     = 4;
	localparam int QDEPTH    = 4;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// header parser positions
	localparam logic [POS_W-1:0] POS_TARGET     = 4'd0;
	localparam logic [POS_W-1:0] POS_SIZE       = 4'd1;
	localparam logic [POS_W-1:0] POS_SOURCE     = 4'd2;
	localparam logic [POS_W-1:0] POS_CORE_FIRST = 4'd3;
	localparam logic [POS_W-1:0] POS_CORE_LAST  = 4'd6;
	localparam logic [POS_W-1:0] POS_NET_FIRST  = 4'd9;
	localparam logic [POS_W-1:0] POS_NET_LAST   = 4'd12;
	localparam logic [POS_W-1:0] POS_PAYLOAD    = 4'd13;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_STOP   = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_IDLE_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 16'd1000;

	typedef struct packed {
		logic [MAX_PORTS-1:0] flit_valid;
		logic [63:0]          flits;
		logic                 finish;
	} nplm_item_t;

	typedef struct packed {
		logic               kind;
		logic [1:0]         port;
		logic [FIELD_W-1:0] target;
		logic [FIELD_W-1:0] size;
		logic [FIELD_W-1:0] source;
		logic [STAMP_W-1:0] core_stamp;
		logic [STAMP_W-1:0] net_stamp;
		logic [STAMP_W-1:0] exit_cycle;
		logic [STAMP_W-1:0] latency;
		logic               last;
	} nplm_rec_t;

	typedef struct packed {
		logic [FIELD_W-1:0] target;
		logic [FIELD_W-1:0] size;
		logic [FIELD_W-1:0] source;
		logic [STAMP_W-1:0] core_stamp;
		logic [STAMP_W-1:0] net_stamp;
	} nplm_pkt_t;

	// everything one accepted item produces
	typedef struct packed {
		nplm_pkt_t [MAX_PORTS-1:0] pkts;
		logic [MAX_PORTS-1:0]      mask;
		logic                      stop;
		logic [STAMP_W-1:0]        exit_cycle;
	} nplm_bundle_t;

endpackage

`default_nettype wire

// ===== hdl/nplm_front.sv =====
// ----------------------------------------------------------------------------
// nplm_front
// Per-port header parsers, in-flight count, idle timeout and cycle counter.
// Pushes one bundle per item that completes a packet or stops the block.
// ----------------------------------------------------------------------------
`default_nettype none

module nplm_front
	import nplm_pkg::*;
#(
	parameter int PORTS     = 4,
	parameter int FLIT_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire nplm_item_t         item,
	input  wire logic [LIMIT_W-1:0] idle_limit,
	input  wire logic               q_full,
	output logic                    push,
	output nplm_bundle_t            push_data
);

	logic [POS_W-1:0]     pos_q   [PORTS];
	logic [FLIT_BITS-1:0] rem_q   [PORTS];
	logic [STAMP_W-1:0]   core_q  [PORTS];
	logic [STAMP_W-1:0]   net_q   [PORTS];
	logic [FIELD_W-1:0]   tgt_q   [PORTS];
	logic [FIELD_W-1:0]   size_q  [PORTS];
	logic [FIELD_W-1:0]   src_q   [PORTS];

	logic [POS_W-1:0]     pos_d   [PORTS];
	logic [FLIT_BITS-1:0] rem_d   [PORTS];
	logic [STAMP_W-1:0]   core_d  [PORTS];
	logic [STAMP_W-1:0]   net_d   [PORTS];
	logic [FIELD_W-1:0]   tgt_d   [PORTS];
	logic [FIELD_W-1:0]   size_d  [PORTS];
	logic [FIELD_W-1:0]   src_d   [PORTS];
	logic [MAX_PORTS-1:0] starts;
	logic [MAX_PORTS-1:0] ends;

	logic [INFL_W-1:0]  in_flight_q, in_flight_d;
	logic [IDLE_W-1:0]  idle_q, idle_d, idle_inc;
	logic [STAMP_W-1:0] cycle_q;
	logic               halted_q;
	logic               stop;
	logic               accept, take;
	logic [INFL_W-1:0]  n_start, n_end;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;
	// once halted, requests are still taken but leave no trace
	assign take       = accept && !halted_q;

	always_comb begin
		logic [FLIT_BITS-1:0] f;
		logic [1:0]           k;
		for (int p = 0; p < PORTS; p++) begin
			f         = item.flits[p*FLIT_BITS +: FLIT_BITS];
			k         = 2'(POS_CORE_LAST - pos_q[p]);
			pos_d[p]  = pos_q[p];
			rem_d[p]  = rem_q[p];
			core_d[p] = core_q[p];
			net_d[p]  = net_q[p];
			tgt_d[p]  = tgt_q[p];
			size_d[p] = size_q[p];
			src_d[p]  = src_q[p];
			starts[p] = 1'b0;
			ends[p]   = 1'b0;
			if (item.flit_valid[p]) begin
				if (pos_q[p] == POS_TARGET) begin
					starts[p] = 1'b1;
					tgt_d[p]  = FIELD_W'(f);
					pos_d[p]  = POS_SIZE;
				end else if (pos_q[p] == POS_SIZE) begin
					size_d[p] = FIELD_W'(f);
					rem_d[p]  = f;
					pos_d[p]  = POS_SOURCE;
				end else begin
					rem_d[p] = rem_q[p] - 1'b1;
					if (pos_q[p] == POS_SOURCE) begin
						src_d[p] = FIELD_W'(f);
					end else if (pos_q[p] <= POS_CORE_LAST) begin
						// high flit first; slots are empty, so insert equals add
						core_d[p][k*FLIT_BITS +: FLIT_BITS] = f;
					end else if (pos_q[p] >= POS_NET_FIRST && pos_q[p] <= POS_NET_LAST) begin
						k = 2'(POS_NET_LAST - pos_q[p]);
						net_d[p][k*FLIT_BITS +: FLIT_BITS] = f;
					end
					if (pos_q[p] < POS_PAYLOAD) begin
						pos_d[p] = pos_q[p] + 1'b1;
					end else if (rem_d[p] == '0) begin
						ends[p]   = 1'b1;
						pos_d[p]  = POS_TARGET;
						core_d[p] = '0;
						net_d[p]  = '0;
					end
				end
			end
		end
		for (int p = PORTS; p < MAX_PORTS; p++) begin
			starts[p] = 1'b0;
			ends[p]   = 1'b0;
		end
	end

	always_comb begin
		n_start = '0;
		n_end   = '0;
		for (int p = 0; p < MAX_PORTS; p++) begin
			n_start = n_start + INFL_W'(starts[p]);
			n_end   = n_end + INFL_W'(ends[p]);
		end
		in_flight_d = in_flight_q + n_start - n_end;
		idle_inc    = (idle_q == {IDLE_W{1'b1}}) ? idle_q : idle_q + 1'b1;
		idle_d      = idle_q;
		stop        = 1'b0;
		if (item.finish) begin
			if (in_flight_d != '0) begin
				idle_d = '0;
			end else begin
				idle_d = idle_inc;
				stop   = idle_inc > IDLE_W'(idle_limit);
			end
		end
	end

	always_comb begin
		push_data            = '0;
		push_data.mask       = ends;
		push_data.stop       = stop;
		push_data.exit_cycle = cycle_q;
		for (int p = 0; p < PORTS; p++) begin
			push_data.pkts[p].target     = tgt_q[p];
			push_data.pkts[p].size       = size_q[p];
			push_data.pkts[p].source     = src_q[p];
			push_data.pkts[p].core_stamp = core_q[p];
			push_data.pkts[p].net_stamp  = net_q[p];
		end
		push = take && (ends != '0 || stop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
			idle_q      <= '0;
			cycle_q     <= '0;
			halted_q    <= 1'b0;
			for (int p = 0; p < PORTS; p++) begin
				pos_q[p]  <= POS_TARGET;
				rem_q[p]  <= '0;
				core_q[p] <= '0;
				net_q[p]  <= '0;
			end
		end else if (take) begin
			in_flight_q <= in_flight_d;
			idle_q      <= idle_d;
			cycle_q     <= cycle_q + 1'b1;
			halted_q    <= stop;
			for (int p = 0; p < PORTS; p++) begin
				pos_q[p]  <= pos_d[p];
				rem_q[p]  <= rem_d[p];
				core_q[p] <= core_d[p];
				net_q[p]  <= net_d[p];
			end
		end
	end

	// header holds: no reset
	always_ff @(posedge clk) begin
		if (take) begin
			for (int p = 0; p < PORTS; p++) begin
				tgt_q[p]  <= tgt_d[p];
				size_q[p] <= size_d[p];
				src_q[p]  <= src_d[p];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nplm_queue.sv =====
// ----------------------------------------------------------------------------
// nplm_queue
// Short bundle queue between the parsers and the record serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module nplm_queue
	import nplm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire nplm_bundle_t push_data,
	input  wire logic         pop,
	output logic              full,
	output logic              head_valid,
	output nplm_bundle_t      head
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	nplm_bundle_t     entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nplm_back.sv =====
// ----------------------------------------------------------------------------
// nplm_back
// Walks the head bundle one record per unstalled cycle, lowest port first,
// then the stop record; computes latency and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nplm_back
	import nplm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire nplm_bundle_t head,
	output logic              pop,
	output logic              rec_valid,
	input  wire logic         rec_stall,
	output nplm_rec_t         rec
);

	logic [MAX_PORTS-1:0] done_q;
	logic [MAX_PORTS-1:0] remaining, sel_oh, rest;
	logic [1:0]           sel_idx;
	logic                 emit_pkt, emit_stop, is_last, can_load, load;
	logic                 rec_valid_q;
	nplm_rec_t            rec_q, rec_d;
	nplm_pkt_t            pkt;

	assign remaining = head_valid ? (head.mask & ~done_q) : '0;

	always_comb begin
		sel_idx = '0;
		sel_oh  = '0;
		for (int p = MAX_PORTS - 1; p >= 0; p--) begin
			if (remaining[p]) begin
				sel_idx = 2'(p);
				sel_oh  = MAX_PORTS'(1) << p;
			end
		end
	end

	assign rest      = remaining & ~sel_oh;
	assign emit_pkt  = remaining != '0;
	assign emit_stop = head_valid && remaining == '0 && head.stop;
	assign is_last   = emit_stop || (rest == '0 && !head.stop);
	assign can_load  = !rec_valid_q || !rec_stall;
	assign load      = can_load && (emit_pkt || emit_stop);
	assign pop       = load && is_last;
	assign pkt       = head.pkts[sel_idx];

	always_comb begin
		rec_d            = '0;
		rec_d.exit_cycle = head.exit_cycle;
		rec_d.last       = is_last;
		if (emit_pkt) begin
			rec_d.kind       = KIND_PACKET;
			rec_d.port       = sel_idx;
			rec_d.target     = pkt.target;
			rec_d.size       = pkt.size;
			rec_d.source     = pkt.source;
			rec_d.core_stamp = pkt.core_stamp;
			rec_d.net_stamp  = pkt.net_stamp;
			rec_d.latency    = head.exit_cycle - pkt.core_stamp;
		end else begin
			rec_d.kind = KIND_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | sel_oh;
			end
			if (can_load) begin
				rec_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_d;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	// progress through a bundle only while one is at the head
	a_done_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid || done_q == '0)
		else $error("emitted-port mask set with empty queue");

	a_done_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (done_q & ~head.mask) == '0)
		else $error("emitted port not part of head bundle");

	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rec_valid && rec.last)
		else $error("bundle popped without its final record");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec.kind == KIND_PACKET) |->
			rec.latency == rec.exit_cycle - rec.core_stamp)
		else $error("latency does not match stamps");

endmodule

`default_nettype wire

// ===== hdl/noc_packet_latency_monitor.sv =====
// ----------------------------------------------------------------------------
// noc_packet_latency_monitor
// Packet latency monitor for the local output ports of a network on chip.
//
// item channel: one request per observed cycle, a flit valid mask, one flit
//   per port and the finish flag. Requests are taken one per clock while
//   item_stall is low; per-port header parsers update when one is accepted.
// rec channel: one record per clock while rec_stall is low, completed packets
//   in ascending port order then the stop record; last marks the final
//   record of a request. An accepted request's bundle enters the queue and
//   its first record is then loaded into the output register.
// Throughput: one request per cycle while records drain at least as fast as
//   they are made; the serializer sends one record per clock, so a request
//   completing k packets gives it k records (plus one for a stop). A
//   four-entry bundle queue absorbs bursts; item_stall rises when it fills.
// Stall: while rec_stall is high the record holds, the queue fills and then
//   item_stall is raised. After the request that stops the block, requests
//   are still taken but produce nothing.
// Reset: parsers, counters and queue clear; idle_limit returns to 1000.
// Config: APB register idle_limit at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module noc_packet_latency_monitor
	import nplm_pkg::*;
#(
	parameter int PORTS     = 4,
	parameter int FLIT_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire nplm_item_t         item,
	output logic                    rec_valid,
	input  wire logic               rec_stall,
	output nplm_rec_t               rec,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [LIMIT_W-1:0] idle_limit_q;
	logic               q_full, push, pop, head_valid;
	nplm_bundle_t       push_data, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_LIMIT) begin
			idle_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDLE_LIMIT) begin
			prdata = PDATA_W'(idle_limit_q);
		end
	end

	nplm_front #(
		.PORTS     (PORTS),
		.FLIT_BITS (FLIT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.idle_limit (idle_limit_q),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	nplm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	nplm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for noc_packet_latency_monitor. Per-port packet streams
// are fed through the request channel. A scoreboard parses every accepted
// request the way the monitor should and checks each record in order. It
// covers header extremes, the idle timeout with its register settings, and
// back-pressure from a long receiver hold.
// ----------------------------------------------------------------------------

module tb;
	import nplm_pkg::*;

	class latency_scoreboard;
		bit [POS_W-1:0]   pos [MAX_PORTS];
		bit [FIELD_W-1:0] remain [MAX_PORTS];
		bit [FIELD_W-1:0] tgt [MAX_PORTS];
		bit [FIELD_W-1:0] sz [MAX_PORTS];
		bit [FIELD_W-1:0] src [MAX_PORTS];
		bit [STAMP_W-1:0] core_acc [MAX_PORTS];
		bit [STAMP_W-1:0] net_acc [MAX_PORTS];
		bit [INFL_W-1:0]  in_flight;
		bit [IDLE_W-1:0]  idle;
		bit [STAMP_W-1:0] cycles;
		bit [LIMIT_W-1:0] idle_limit;
		bit               halted;
		nplm_rec_t        expected_records [$];
		int               errors, requests, packets, stops;

		function new();
			idle_limit = IDLE_LIMIT_RESET;
		endfunction

		function void set_limit(bit [LIMIT_W-1:0] v);
			idle_limit = v;
		endfunction

		function void add_expected(nplm_rec_t r);
			expected_records.insert(expected_records.size(), r);
		endfunction

		function void note_request(nplm_item_t it);
			bit [FIELD_W-1:0] f;
			nplm_rec_t        r;
			int               n0;
			requests++;
			if (halted)
				return;
			n0 = expected_records.size();
			for (int p = 0; p < MAX_PORTS; p++) begin
				if (!it.flit_valid[p])
					continue;
				f = it.flits[p*FIELD_W +: FIELD_W];
				if (pos[p] == POS_TARGET) begin
					in_flight = in_flight + 1'b1;
					tgt[p] = f;
					pos[p] = POS_SIZE;
				end else if (pos[p] == POS_SIZE) begin
					sz[p] = f;
					remain[p] = f;
					pos[p] = POS_SOURCE;
				end else begin
					remain[p] = remain[p] - 1'b1;
					if (pos[p] == POS_SOURCE) begin
						src[p] = f;
					end else if (pos[p] <= POS_CORE_LAST) begin
						core_acc[p] += STAMP_W'(f) << (FIELD_W * int'(POS_CORE_LAST - pos[p]));
					end else if (pos[p] >= POS_NET_FIRST && pos[p] <= POS_NET_LAST) begin
						net_acc[p] += STAMP_W'(f) << (FIELD_W * int'(POS_NET_LAST - pos[p]));
					end
					if (pos[p] != POS_PAYLOAD) begin
						pos[p] = pos[p] + 1'b1;
					end else if (remain[p] == 0) begin
						r = '0;
						r.kind = KIND_PACKET;
						r.port = 2'(p);
						r.target = tgt[p];
						r.size = sz[p];
						r.source = src[p];
						r.core_stamp = core_acc[p];
						r.net_stamp = net_acc[p];
						r.exit_cycle = cycles;
						r.latency = cycles - core_acc[p];
						add_expected(r);
						pos[p] = POS_TARGET;
						in_flight = in_flight - 1'b1;
						core_acc[p] = '0;
						net_acc[p] = '0;
					end
				end
			end
			if (it.finish) begin
				if (in_flight != 0) begin
					idle = '0;
				end else begin
					if (idle != '1)
						idle = idle + 1'b1;
					if (idle > idle_limit) begin
						r = '0;
						r.kind = KIND_STOP;
						r.exit_cycle = cycles;
						add_expected(r);
						halted = 1'b1;
					end
				end
			end
			cycles = cycles + 1'b1;
			if (expected_records.size() > n0)
				expected_records[expected_records.size()-1].last = 1'b1;
		endfunction

		function void cmp(string name, logic [STAMP_W-1:0] e, logic [STAMP_W-1:0] g);
			if (g !== e) begin
				$error("%s mismatch: expected %h, got %h", name, e, g);
				errors++;
			end
		endfunction

		function void check_record(nplm_rec_t got);
			nplm_rec_t e;
			if (expected_records.size() == 0) begin
				$error("record with nothing expected: %p", got);
				errors++;
				return;
			end
			e = expected_records.pop_front();
			if (e.kind == KIND_STOP)
				stops++;
			else
				packets++;
			cmp("kind", STAMP_W'(e.kind), STAMP_W'(got.kind));
			cmp("port", STAMP_W'(e.port), STAMP_W'(got.port));
			cmp("target", STAMP_W'(e.target), STAMP_W'(got.target));
			cmp("size", STAMP_W'(e.size), STAMP_W'(got.size));
			cmp("source", STAMP_W'(e.source), STAMP_W'(got.source));
			cmp("core_stamp", e.core_stamp, got.core_stamp);
			cmp("net_stamp", e.net_stamp, got.net_stamp);
			cmp("exit_cycle", e.exit_cycle, got.exit_cycle);
			cmp("latency", e.latency, got.latency);
			cmp("last", STAMP_W'(e.last), STAMP_W'(got.last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	nplm_item_t         item;
	logic               rec_valid;
	logic               rec_stall;
	nplm_rec_t          rec;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	latency_scoreboard sb = new();

	bit [FIELD_W-1:0] port_q [MAX_PORTS][$];
	bit               quiet;
	bit               tx_calm;
	bit               press_req;
	bit [LIMIT_W-1:0] mid_limit;

	noc_packet_latency_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void put_flit(int p, bit [FIELD_W-1:0] v);
		port_q[p].insert(port_q[p].size(), v);
	endfunction

	// header flits, the timestamps high flit first, then the payload the size calls for
	function automatic void queue_packet(int p, bit [FIELD_W-1:0] target, bit [FIELD_W-1:0] size,
			bit [FIELD_W-1:0] source, bit [STAMP_W-1:0] core, bit [STAMP_W-1:0] net);
		int n;
		put_flit(p, target);
		put_flit(p, size);
		put_flit(p, source);
		for (int i = 3; i >= 0; i--)
			put_flit(p, core[i*FIELD_W +: FIELD_W]);
		put_flit(p, FIELD_W'($urandom));
		put_flit(p, FIELD_W'($urandom));
		for (int i = 3; i >= 0; i--)
			put_flit(p, net[i*FIELD_W +: FIELD_W]);
		// sizes below 12 wrap the count into a payload of nearly 2^16 flits
		n = (int'(size) + 65536 - 11) % 65536;
		if (n == 0)
			n = 65536;
		repeat (n) put_flit(p, FIELD_W'($urandom));
	endfunction

	function automatic nplm_item_t build_item(bit [MAX_PORTS-1:0] want, bit fin);
		nplm_item_t      it;
		bit [STAMP_W-1:0] core;
		it.flits = {$urandom, $urandom};
		it.flit_valid = '0;
		it.finish = fin;
		for (int p = 0; p < MAX_PORTS; p++) begin
			if (!want[p])
				continue;
			if (port_q[p].size() == 0) begin
				core = $urandom_range(0, 1) ? {$urandom, $urandom}
					: sb.cycles - $urandom_range(0, 500);
				queue_packet(p, FIELD_W'($urandom),
					FIELD_W'($urandom_range(0, 7) == 0 ? $urandom_range(19, 40)
						: $urandom_range(12, 18)),
					FIELD_W'($urandom), core, {$urandom, $urandom});
			end
			it.flits[p*FIELD_W +: FIELD_W] = port_q[p].pop_front();
			it.flit_valid[p] = 1'b1;
		end
		return it;
	endfunction

	task automatic send_item(input nplm_item_t it);
		if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_request(it);
	endtask

	task automatic drain_ports(input bit fin);
		bit [MAX_PORTS-1:0] busy;
		forever begin
			for (int p = 0; p < MAX_PORTS; p++)
				busy[p] = port_q[p].size() != 0;
			if (busy == '0)
				break;
			send_item(build_item(busy, fin));
		end
	endtask

	// leaves the block idle: no request offered, all records in, pipeline flushed
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.expected_records.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_IDLE_LIMIT, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_limit_reg();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd !== PDATA_W'(sb.idle_limit)) begin
			$error("idle_limit readback mismatch: expected %h, got %h", sb.idle_limit, rd);
			sb.errors++;
		end
	endtask

	task automatic set_idle_limit(input bit [LIMIT_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, PDATA_W'(v), rd);
		sb.set_limit(v);
		check_limit_reg();
	endtask

	// receiving side: random stall bursts, calm stretches, one long hold
	initial begin : rx_side
		int hold_cnt;
		int tick;
		bit rx_calm;
		hold_cnt = 0;
		tick = 0;
		rx_calm = 1'b0;
		rec_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rec_valid && !rec_stall)
				sb.check_record(rec);
			tick++;
			if (tick % 64 == 0)
				rx_calm = $urandom_range(0, 3) == 0;
			if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (press_req) begin
				hold_cnt = 160;
				press_req = 1'b0;
			end else if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
				hold_cnt = $urandom_range(1, 8);
			end
			rec_stall <= hold_cnt > 0;
		end
	end

	initial begin : main_seq
		int n;
		bit [MAX_PORTS-1:0] want;
		nplm_item_t noise;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_limit_reg();

		// header extremes, all four ports ending on the same request
		queue_packet(0, '1, 16'd12, '0, '1, '0);
		queue_packet(1, '0, 16'd12, '1, '0, '1);
		queue_packet(2, FIELD_W'($urandom), 16'd12, FIELD_W'($urandom),
			64'h8000_0000_0000_0000, {$urandom, $urandom});
		queue_packet(3, FIELD_W'($urandom), 16'd12, FIELD_W'($urandom), 64'd5,
			{$urandom, $urandom});
		drain_ports(1'b1);
		// idle counting with finish, then finish dropped
		repeat (3) send_item(build_item('0, 1'b1));
		repeat (2) send_item(build_item('0, 1'b0));
		wait_idle();

		// register at its top value
		set_idle_limit('1);

		mid_limit = LIMIT_W'($urandom_range(2000, 60000));
		set_idle_limit(mid_limit);
		press_req = 1'b1;
		n = 0;
		while (n < 100) begin
			if (n % 40 == 0)
				tx_calm = $urandom_range(0, 3) == 0;
			if ($urandom_range(0, 4) == 0) begin
				want = MAX_PORTS'($urandom);
			end else begin
				for (int p = 0; p < MAX_PORTS; p++)
					want[p] = $urandom_range(0, 3) != 0;
			end
			send_item(build_item(want, $urandom_range(0, 3) == 0));
			n++;
		end

		// close every open packet so nothing is in flight
		quiet = 1'b1;
		drain_ports(1'b1);
		wait_idle();

		// limit zero: four packets and the stop record on one request
		set_idle_limit('0);
		for (int p = 0; p < MAX_PORTS; p++)
			queue_packet(p, FIELD_W'($urandom), 16'd12, FIELD_W'($urandom),
				{$urandom, $urandom}, {$urandom, $urandom});
		drain_ports(1'b1);
		// halted: requests are taken but must produce nothing
		repeat (6) begin
			noise.flit_valid = MAX_PORTS'($urandom);
			noise.flits = {$urandom, $urandom};
			noise.finish = 1'($urandom);
			send_item(noise);
		end
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Checked %0d packet records and %0d stop record over %0d requests.",
			sb.packets, sb.stops, sb.requests);
		$display("idle_limit settings: 1000, 65535, %0d, 0; packets of 14 to 42 flits.",
			mid_limit);
		if (sb.errors == 0 && sb.expected_records.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
